@@ rtl/core/cpse_pkg.sv @@
package cpse_pkg;

    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 32;
    localparam int HW_W        = 10;
    localparam int INDEX_WIDTH = 16;
    localparam int QBASE_W     = 16;
    localparam int CORNER_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Serial arithmetic sizes.
    localparam int MUL_M_W     = 32;
    localparam int MUL_Q_W     = 20;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int S_W         = SQ_W + 1;
    localparam int QUO_W       = 22;
    localparam int ROOT_W      = QUO_W / 2;
    localparam int SREM_W      = ROOT_W + 1;
    localparam int SUM_W       = COORD_W + 2;
    localparam int OFS_W       = HW_W + 1;
    localparam int CNT_W       = 5;

    localparam int MUL_STEPS   = MUL_Q_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int SQRT_STEPS  = ROOT_W;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    localparam logic [INDEX_WIDTH-1:0] VERTS_PER_QUAD = INDEX_WIDTH'(4);
    localparam logic [CORNER_W-1:0]    CORNER_FIRST   = CORNER_W'(0);
    localparam logic [CORNER_W-1:0]    CORNER_LAST    = CORNER_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_BASE = CFG_IDX_W'(2);

    localparam logic [COLOR_W-1:0] COLOR_RESET = '1;
    localparam logic [HW_W-1:0]    HW_RESET    = HW_W'(8);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_MDONE,
        S_DIV,
        S_SQRT,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MUL_HW2,
        MUL_AX2,
        MUL_AY2,
        MUL_NX,
        MUL_NY
    } t_mul;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > $signed(SUM_W'(32767))) begin
            res = 16'sh7fff;
        end else if (v < -$signed(SUM_W'(32768))) begin
            res = 16'sh8000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/cpse_if.sv @@
interface cpse_pt_if import cpse_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;

    modport source(output valid, point_x, point_y, last_point, input ready);
    modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface cpse_vtx_if import cpse_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic [COLOR_W-1:0]        vert_color;
    logic [CORNER_W-1:0]       corner;
    logic [QBASE_W-1:0]        quad_base;
    logic                      last_of_run;

    modport source(output valid, vert_x, vert_y, vert_color, corner, quad_base, last_of_run,
                   input ready);
    modport sink(input valid, vert_x, vert_y, vert_color, corner, quad_base, last_of_run,
                 output ready);
endinterface

interface cpse_cfg_if import cpse_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/closed_polyline_stroke_expander_unit.sv @@
// A point's beat is taken only while idle; a first point is only stored. Each quad runs
// through setup, the shared bit-serial multiplier (five products), the radix-2 divider
// and the square root, both per axis; its four vertices then leave one per cycle while
// the output is not stalled. A zero-length segment goes from the third product straight
// to the output; a closing point (two quads) adds the quad back to the first point.
// Synchronous active-low reset: polyline state and counter zero, line_color ones, half_width 8.
module closed_polyline_stroke_expander_unit import cpse_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    cpse_pt_if.sink     i_pt,
    cpse_vtx_if.source  o_vtx,
    cpse_cfg_if.sink    i_cfg
);

    // Control registers.
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    t_mul                   r_mul, n_mul;
    logic                   r_axis, n_axis;
    logic [CORNER_W-1:0]    r_corner, n_corner;
    logic                   r_close, n_close;
    logic [1:0]             r_pseen, n_pseen;
    logic [INDEX_WIDTH-1:0] r_vcnt, n_vcnt;
    logic [COLOR_W-1:0]     r_color, n_color;
    logic [HW_W-1:0]        r_hw, n_hw;
    logic                   r_out_valid, n_out_valid;

    // Points and segment.
    logic signed [COORD_W-1:0] r_fx, n_fx, r_fy, n_fy, r_px, n_px, r_py, n_py;
    logic signed [COORD_W-1:0] r_p1x, n_p1x, r_p1y, n_p1y, r_p2x, n_p2x, r_p2y, n_p2y;
    logic [COORD_W-1:0]        r_ax, n_ax, r_ay, n_ay;
    logic                      r_negx, n_negx, r_negy, n_negy;

    // Arithmetic datapath.
    logic [2*HW_W-1:0]   r_hw2, n_hw2;
    logic [SQ_W-1:0]     r_ax2, n_ax2, r_ay2, n_ay2;
    logic [S_W-1:0]      r_s, n_s;
    logic [MUL_M_W-1:0]  r_acc, n_acc, r_mc, n_mc;
    logic [MUL_Q_W-1:0]  r_mq, n_mq;
    logic [S_W-1:0]      r_rem, n_rem;
    logic [QUO_W-1:0]    r_dsh, n_dsh, r_quo, n_quo, r_srad, n_srad;
    logic [SREM_W-1:0]   r_srem, n_srem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [HW_W-1:0]     r_mx, n_mx, r_my, n_my;

    // Output register.
    logic signed [COORD_W-1:0] r_ovx, n_ovx, r_ovy, n_ovy;
    logic [COLOR_W-1:0]        r_ocol, n_ocol;
    logic [CORNER_W-1:0]       r_ocorner, n_ocorner;
    logic [QBASE_W-1:0]        r_obase, n_obase;
    logic                      r_olast, n_olast;

    // Combinational helpers.
    logic [COORD_W:0]          dx, dy, adx, ady;
    logic [MUL_M_W:0]          mul_sum;
    logic [SQ_W-1:0]           prod32;
    logic [S_W-1:0]            s_sum;
    logic [S_W:0]              div_t, div_diff;
    logic                      div_ge;
    logic [QUO_W-1:0]          quo_nx;
    logic [SREM_W+1:0]         sq_rem2, sq_trial, sq_diff;
    logic                      sq_ge;
    logic [ROOT_W-1:0]         root_nx;
    logic [ROOT_W:0]           kp1;
    logic [HW_W-1:0]           m_val;
    logic signed [OFS_W-1:0]   ox, oy, offx, offy;
    logic signed [COORD_W-1:0] bx, by;
    logic [SUM_W-1:0]          sumx, sumy;
    logic                      out_free;

    assign i_pt.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_vtx.valid       = r_out_valid;
    assign o_vtx.vert_x      = r_ovx;
    assign o_vtx.vert_y      = r_ovy;
    assign o_vtx.vert_color  = r_ocol;
    assign o_vtx.corner      = r_ocorner;
    assign o_vtx.quad_base   = r_obase;
    assign o_vtx.last_of_run = r_olast;

    assign out_free = !r_out_valid || o_vtx.ready;

    // Direction p1 - p2 and its magnitude per axis.
    assign dx  = {r_p1x[COORD_W-1], r_p1x} - {r_p2x[COORD_W-1], r_p2x};
    assign dy  = {r_p1y[COORD_W-1], r_p1y} - {r_p2y[COORD_W-1], r_p2y};
    assign adx = dx[COORD_W] ? -dx : dx;
    assign ady = dy[COORD_W] ? -dy : dy;

    // Shift-add multiplier: one multiplier bit per cycle, product ends up in {acc, mq}.
    assign mul_sum = {1'b0, r_acc} + (r_mq[0] ? {1'b0, r_mc} : '0);
    assign prod32  = {r_acc[SQ_W-MUL_Q_W-1:0], r_mq};
    assign s_sum   = {1'b0, r_ax2} + {1'b0, prod32};

    // Restoring divider, one quotient bit per cycle.
    assign div_t    = {r_rem, r_dsh[QUO_W-1]};
    assign div_diff = div_t - {1'b0, r_s};
    assign div_ge   = (div_t >= {1'b0, r_s});
    assign quo_nx   = {r_quo[QUO_W-2:0], div_ge};

    // Digit-by-digit square root, two radicand bits per cycle.
    assign sq_rem2  = {r_srem, r_srad[QUO_W-1:QUO_W-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_diff  = sq_rem2 - sq_trial;
    assign sq_ge    = (sq_rem2 >= sq_trial);
    assign root_nx  = {r_root[ROOT_W-2:0], sq_ge};

    // The root k is the largest integer with k*k*s <= (2*a*hw)^2; rounding to nearest
    // with ties away from zero then gives (k + 1) / 2.
    assign kp1   = {1'b0, root_nx} + (ROOT_W+1)'(1);
    assign m_val = (kp1[ROOT_W:1] > {1'b0, r_hw}) ? r_hw : kp1[HW_W:1];

    // Corners 0 and 3 sit on p1, corners 2 and 3 take the negated offset.
    assign ox   = r_negx ? -$signed({1'b0, r_mx}) : $signed({1'b0, r_mx});
    assign oy   = r_negy ? -$signed({1'b0, r_my}) : $signed({1'b0, r_my});
    assign bx   = (r_corner[0] ~^ r_corner[1]) ? r_p1x : r_p2x;
    assign by   = (r_corner[0] ~^ r_corner[1]) ? r_p1y : r_p2y;
    assign offx = r_corner[1] ? -oy : oy;
    assign offy = r_corner[1] ? ox : -ox;
    assign sumx = {{2{bx[COORD_W-1]}}, bx} + {{(SUM_W-OFS_W){offx[OFS_W-1]}}, offx};
    assign sumy = {{2{by[COORD_W-1]}}, by} + {{(SUM_W-OFS_W){offy[OFS_W-1]}}, offy};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mul       = r_mul;
        n_axis      = r_axis;
        n_corner    = r_corner;
        n_close     = r_close;
        n_pseen     = r_pseen;
        n_vcnt      = r_vcnt;
        n_color     = r_color;
        n_hw        = r_hw;
        n_out_valid = r_out_valid;
        n_fx  = r_fx;  n_fy  = r_fy;  n_px  = r_px;  n_py  = r_py;
        n_p1x = r_p1x; n_p1y = r_p1y; n_p2x = r_p2x; n_p2y = r_p2y;
        n_ax  = r_ax;  n_ay  = r_ay;  n_negx = r_negx; n_negy = r_negy;
        n_hw2 = r_hw2; n_ax2 = r_ax2; n_ay2 = r_ay2; n_s = r_s;
        n_acc = r_acc; n_mc = r_mc; n_mq = r_mq;
        n_rem = r_rem; n_dsh = r_dsh; n_quo = r_quo;
        n_srad = r_srad; n_srem = r_srem; n_root = r_root;
        n_mx = r_mx; n_my = r_my;
        n_ovx = r_ovx; n_ovy = r_ovy; n_ocol = r_ocol;
        n_ocorner = r_ocorner; n_obase = r_obase; n_olast = r_olast;

        if (r_out_valid && o_vtx.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    n_px = i_pt.point_x;
                    n_py = i_pt.point_y;
                    if (r_pseen == 2'd0) begin
                        n_fx    = i_pt.point_x;
                        n_fy    = i_pt.point_y;
                        n_pseen = i_pt.last_point ? 2'd0 : 2'd1;
                    end else begin
                        n_p1x   = r_px;
                        n_p1y   = r_py;
                        n_p2x   = i_pt.point_x;
                        n_p2y   = i_pt.point_y;
                        n_close = i_pt.last_point;
                        n_pseen = i_pt.last_point ? 2'd0 : 2'd2;
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_ax    = adx[COORD_W-1:0];
                n_ay    = ady[COORD_W-1:0];
                n_negx  = dx[COORD_W];
                n_negy  = dy[COORD_W];
                n_mc    = MUL_M_W'(r_hw);
                n_mq    = MUL_Q_W'(r_hw);
                n_acc   = '0;
                n_cnt   = '0;
                n_mul   = MUL_HW2;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_acc = mul_sum[MUL_M_W:1];
                n_mq  = {mul_sum[0], r_mq[MUL_Q_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_MDONE;
                end
            end
            S_MDONE: begin
                n_acc = '0;
                n_cnt = '0;
                case (r_mul)
                    MUL_HW2: begin
                        n_hw2   = r_mq;
                        n_mc    = MUL_M_W'(r_ax);
                        n_mq    = MUL_Q_W'(r_ax);
                        n_mul   = MUL_AX2;
                        n_state = S_MUL;
                    end
                    MUL_AX2: begin
                        n_ax2   = prod32;
                        n_mc    = MUL_M_W'(r_ay);
                        n_mq    = MUL_Q_W'(r_ay);
                        n_mul   = MUL_AY2;
                        n_state = S_MUL;
                    end
                    MUL_AY2: begin
                        n_ay2 = prod32;
                        n_s   = s_sum;
                        if (s_sum == '0) begin
                            // A zero-length segment puts all four corners on the point.
                            n_mx     = '0;
                            n_my     = '0;
                            n_corner = CORNER_FIRST;
                            n_state  = S_EMIT;
                        end else begin
                            n_mc    = r_ax2;
                            n_mq    = r_hw2;
                            n_mul   = MUL_NX;
                            n_state = S_MUL;
                        end
                    end
                    MUL_NX, MUL_NY: begin
                        // Dividend is 4 * a^2 * hw^2; the quotient stays below 2^22, so the
                        // top part starts below s.
                        n_rem   = {1'b0, r_acc};
                        n_dsh   = {r_mq, 2'b00};
                        n_quo   = '0;
                        n_axis  = (r_mul == MUL_NY);
                        n_state = S_DIV;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff[S_W-1:0] : div_t[S_W-1:0];
                n_dsh = {r_dsh[QUO_W-2:0], 1'b0};
                n_quo = quo_nx;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_srad  = quo_nx;
                    n_srem  = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_srad = {r_srad[QUO_W-3:0], 2'b00};
                n_srem = sq_ge ? sq_diff[SREM_W-1:0] : sq_rem2[SREM_W-1:0];
                n_root = root_nx;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_cnt = '0;
                    if (!r_axis) begin
                        n_mx    = m_val;
                        n_mc    = r_ay2;
                        n_mq    = r_hw2;
                        n_acc   = '0;
                        n_mul   = MUL_NY;
                        n_state = S_MUL;
                    end else begin
                        n_my     = m_val;
                        n_corner = CORNER_FIRST;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_ovx       = sat16(sumx);
                    n_ovy       = sat16(sumy);
                    n_ocol      = r_color;
                    n_ocorner   = r_corner;
                    n_obase     = r_vcnt[QBASE_W-1:0];
                    n_olast     = (r_corner == CORNER_LAST) && !r_close;
                    n_corner    = r_corner + 1'b1;
                    if (r_corner == CORNER_LAST) begin
                        n_vcnt = r_vcnt + VERTS_PER_QUAD;
                        if (r_close) begin
                            // Closing segment runs from the last point back to the first.
                            n_close = 1'b0;
                            n_p1x   = r_p2x;
                            n_p1y   = r_p2y;
                            n_p2x   = r_fx;
                            n_p2y   = r_fy;
                            n_state = S_SETUP;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LINE_COLOR: begin
                    n_color = i_cfg.data[COLOR_W-1:0];
                end
                CFG_HALF_WIDTH: begin
                    n_hw = i_cfg.data[HW_W-1:0];
                end
                CFG_VERTEX_BASE: begin
                    n_vcnt = INDEX_WIDTH'(i_cfg.data[QBASE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mul       <= MUL_HW2;
            r_axis      <= 1'b0;
            r_corner    <= CORNER_FIRST;
            r_close     <= 1'b0;
            r_pseen     <= 2'd0;
            r_vcnt      <= '0;
            r_color     <= COLOR_RESET;
            r_hw        <= HW_RESET;
            r_out_valid <= 1'b0;
            r_fx        <= '0;
            r_fy        <= '0;
            r_px        <= '0;
            r_py        <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mul       <= n_mul;
            r_axis      <= n_axis;
            r_corner    <= n_corner;
            r_close     <= n_close;
            r_pseen     <= n_pseen;
            r_vcnt      <= n_vcnt;
            r_color     <= n_color;
            r_hw        <= n_hw;
            r_out_valid <= n_out_valid;
            r_fx        <= n_fx;
            r_fy        <= n_fy;
            r_px        <= n_px;
            r_py        <= n_py;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1x     <= n_p1x;
        r_p1y     <= n_p1y;
        r_p2x     <= n_p2x;
        r_p2y     <= n_p2y;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_negx    <= n_negx;
        r_negy    <= n_negy;
        r_hw2     <= n_hw2;
        r_ax2     <= n_ax2;
        r_ay2     <= n_ay2;
        r_s       <= n_s;
        r_acc     <= n_acc;
        r_mc      <= n_mc;
        r_mq      <= n_mq;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_quo     <= n_quo;
        r_srad    <= n_srad;
        r_srem    <= n_srem;
        r_root    <= n_root;
        r_mx      <= n_mx;
        r_my      <= n_my;
        r_ovx     <= n_ovx;
        r_ovy     <= n_ovy;
        r_ocol    <= n_ocol;
        r_ocorner <= n_ocorner;
        r_obase   <= n_obase;
        r_olast   <= n_olast;
    end

    // The partial remainder never reaches the divisor.
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_s))
        else $error("divider remainder not below divisor");

    // The root can never exceed twice the half width, since |a| <= sqrt(s).
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt == SQRT_LAST) |=> (r_root <= {r_hw, 1'b0}))
        else $error("square root beyond twice the half width");

    // A new point is never taken while the closing quad is still pending.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |-> !r_close)
        else $error("point accepted with closing quad pending");

    // The end of a run is only ever flagged on the last corner of a quad.
    a_last_on_corner3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.last_of_run) |-> (o_vtx.corner == CORNER_LAST))
        else $error("run end flagged on a corner other than the last");

endmodule
